/* rtl/tkpp_pkg.sv */
package tkpp_pkg;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int THR_W     = 18;
  localparam int MP_W      = 5;
  localparam int COUNT_W   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PEAKS = 2'd1;

  localparam logic [MP_W-1:0] MAX_PEAKS_RESET = 5'd16;

  // commands broadcast to every store cell
  typedef struct packed {
    logic shift;   // take the right neighbor's entry (drain)
    logic app;     // first empty cell takes the new peak
    logic rep;     // drop the scanned minimum, close the gap, append the new peak
  } cell_cmd_t;

endpackage

/* rtl/tkpp_cell.sv */
module tkpp_cell #(
  parameter int SB  = 16,
  parameter int PW  = 12,
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tkpp_pkg::cell_cmd_t  cmd,
  input  logic [IW-1:0]        min_idx,
  input  logic signed [SB-1:0] new_h,
  input  logic [PW-1:0]        new_pos,
  input  logic                 prev_v,
  input  logic                 nxt_v,
  input  logic signed [SB-1:0] nxt_h,
  input  logic [PW-1:0]        nxt_pos,
  input  logic                 sc_go_in,
  input  logic signed [SB-1:0] sc_h_in,
  input  logic [IW-1:0]        sc_idx_in,
  output logic                 v,
  output logic signed [SB-1:0] h,
  output logic [PW-1:0]        pos,
  output logic                 sc_go_out,
  output logic signed [SB-1:0] sc_h_out,
  output logic [IW-1:0]        sc_idx_out
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                 v_r;
  logic signed [SB-1:0] h_r;
  logic [PW-1:0]        pos_r;
  logic                 sc_go_r;
  logic signed [SB-1:0] sc_h_r;
  logic [IW-1:0]        sc_idx_r;
  logic                 app_here;
  logic                 rep_here;
  logic                 take_own;

  assign app_here = cmd.app && !v_r && prev_v;
  assign rep_here = cmd.rep && v_r && (MY_IDX >= min_idx);
  // first cell seeds the running minimum; strict compare keeps the earliest
  assign take_own = v_r && ((IDX == 0) || (h_r < sc_h_in));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      sc_go_r <= 1'b0;
    end else begin
      sc_go_r <= sc_go_in;
      if (cmd.shift) begin
        v_r <= nxt_v;
      end else if (app_here) begin
        v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      h_r   <= nxt_h;
      pos_r <= nxt_pos;
    end else if (app_here) begin
      h_r   <= new_h;
      pos_r <= new_pos;
    end else if (rep_here) begin
      if (nxt_v) begin
        h_r   <= nxt_h;
        pos_r <= nxt_pos;
      end else begin
        h_r   <= new_h;
        pos_r <= new_pos;
      end
    end
    if (take_own) begin
      sc_h_r   <= h_r;
      sc_idx_r <= MY_IDX;
    end else begin
      sc_h_r   <= sc_h_in;
      sc_idx_r <= sc_idx_in;
    end
  end

  assign v          = v_r;
  assign h          = h_r;
  assign pos        = pos_r;
  assign sc_go_out  = sc_go_r;
  assign sc_h_out   = sc_h_r;
  assign sc_idx_out = sc_idx_r;

endmodule

/* rtl/top_k_concave_peak_picker.sv */
// Peak picker for a stream of spectrum samples. Each sample slides a three-sample
// window; a second difference below concavity_threshold opens a peak, the centre with
// the smallest |y2-y0| is tracked, and a second difference above the threshold closes
// it. Closed peaks go into a row of MAX_PEAKS store cells that keep the tallest
// max_peaks of the frame in arrival order. A sample is taken every cycle, except that
// when a peak closes with the store full the input holds while the minimum search
// walks down the cell row and the store is updated. After the sample flagged
// end_of_frame the input holds until the frame's results are drained,
// one per cycle while out_ready is high: the kept peak positions in ascending order,
// or one result flagged none_found. Samples beyond MAX_FRAME are dropped and flag
// frame_overflow on every result of the frame. Configuration writes are always taken.
module top_k_concave_peak_picker #(
  parameter int MAX_PEAKS   = 16,
  parameter int MAX_FRAME   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  logic                                 in_end_of_frame,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [$clog2(MAX_FRAME)-1:0]         out_peak_index,
  output logic [tkpp_pkg::COUNT_W-1:0]         out_peak_count,
  output logic                                 out_none_found,
  output logic                                 out_frame_overflow,
  output logic                                 out_last_result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tkpp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tkpp_pkg::THR_W-1:0]           cfg_data
);

  localparam int PW  = $clog2(MAX_FRAME);
  localparam int PCW = $clog2(MAX_FRAME + 1);
  localparam int CW  = $clog2(MAX_PEAKS + 1);
  localparam int IW  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int SLW = SAMPLE_BITS + 1;
  localparam int DW  = (SAMPLE_BITS + 3 > tkpp_pkg::THR_W) ? SAMPLE_BITS + 3
                                                            : tkpp_pkg::THR_W;
  localparam int LW  = (CW > tkpp_pkg::MP_W) ? CW : tkpp_pkg::MP_W;

  typedef enum logic [1:0] {S_RUN, S_SCAN, S_DRAIN} state_t;

  state_t state_r, state_nxt;

  logic signed [tkpp_pkg::THR_W-1:0] thr_r;
  logic [tkpp_pkg::MP_W-1:0]         mp_r;
  logic signed [SAMPLE_BITS-1:0]     w0_r, w1_r;
  logic [PCW-1:0]                    pos_r;
  logic                              on_peak_r;
  logic [SLW-1:0]                    best_slope_r;
  logic [PW-1:0]                     best_pos_r;
  logic signed [SAMPLE_BITS-1:0]     best_h_r;
  logic                              ovf_r;
  logic [CW-1:0]                     count_r;
  logic                              eof_pend_r;
  logic signed [SAMPLE_BITS-1:0]     pend_h_r;
  logic [PW-1:0]                     pend_pos_r;

  logic signed [DW-1:0]  y0_x, y1_x, y2_x, d, thr_x;
  logic signed [SLW-1:0] diff;
  logic [SLW-1:0]        slope;
  logic [PW-1:0]         centre;
  logic [LW-1:0]         mp_ext;
  logic [CW-1:0]         lim;
  logic                  full;
  logic                  in_acc, out_acc, in_range, judge_en;
  logic                  start_pk, close_pk, better;
  logic                  scan_start, scan_done, frame_end;

  tkpp_pkg::cell_cmd_t           cmd;
  logic signed [SAMPLE_BITS-1:0] new_h;
  logic [PW-1:0]                 new_pos;

  logic                          v_a      [MAX_PEAKS];
  logic signed [SAMPLE_BITS-1:0] h_a      [MAX_PEAKS];
  logic [PW-1:0]                 pos_a    [MAX_PEAKS];
  logic                          sc_go_a  [MAX_PEAKS];
  logic signed [SAMPLE_BITS-1:0] sc_h_a   [MAX_PEAKS];
  logic [IW-1:0]                 sc_idx_a [MAX_PEAKS];
  logic                          next0_v;

  // window judge
  assign y0_x  = DW'(w0_r);
  assign y1_x  = DW'(w1_r);
  assign y2_x  = DW'(in_sample);
  assign thr_x = DW'(thr_r);
  assign d     = y0_x + y2_x - (y1_x <<< 1);
  assign diff  = SLW'(in_sample) - SLW'(w0_r);
  assign slope = diff[SLW-1] ? SLW'(-diff) : SLW'(diff);
  assign centre = PW'(pos_r - PCW'(1));

  assign mp_ext = LW'(mp_r);
  assign lim = (mp_r == '0) ? CW'(1) :
               ((mp_ext > LW'(MAX_PEAKS)) ? CW'(MAX_PEAKS) : CW'(mp_r));
  assign full = (count_r >= lim);

  assign in_ready  = (state_r == S_RUN);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign in_range  = (pos_r != PCW'(MAX_FRAME));
  assign judge_en  = in_acc && in_range && (pos_r >= PCW'(2));

  assign start_pk = judge_en && !on_peak_r && (d < thr_x);
  assign close_pk = judge_en && on_peak_r && (d > thr_x);
  assign better   = judge_en && on_peak_r && !close_pk && (slope < best_slope_r);

  assign scan_start = close_pk && full;
  assign scan_done  = (state_r == S_SCAN) && sc_go_a[MAX_PEAKS-1];
  assign frame_end  = out_acc && out_last_result;

  always_comb begin
    cmd.shift = out_acc;
    cmd.app   = close_pk && !full;
    cmd.rep   = scan_done && (pend_h_r >= sc_h_a[MAX_PEAKS-1]);
  end

  assign new_h   = (state_r == S_SCAN) ? pend_h_r : best_h_r;
  assign new_pos = (state_r == S_SCAN) ? pend_pos_r : best_pos_r;

  // store cell row
  for (genvar i = 0; i < MAX_PEAKS; i++) begin : g_cell
    logic                          prev_v;
    logic                          nxt_v;
    logic signed [SAMPLE_BITS-1:0] nxt_h;
    logic [PW-1:0]                 nxt_pos;
    logic                          sc_go_in;
    logic signed [SAMPLE_BITS-1:0] sc_h_in;
    logic [IW-1:0]                 sc_idx_in;

    if (i == 0) begin : g_first
      assign prev_v    = 1'b1;
      assign sc_go_in  = scan_start;
      assign sc_h_in   = '0;
      assign sc_idx_in = '0;
    end else begin : g_mid
      assign prev_v    = v_a[i-1];
      assign sc_go_in  = sc_go_a[i-1];
      assign sc_h_in   = sc_h_a[i-1];
      assign sc_idx_in = sc_idx_a[i-1];
    end

    if (i == MAX_PEAKS - 1) begin : g_last
      assign nxt_v   = 1'b0;
      assign nxt_h   = '0;
      assign nxt_pos = '0;
    end else begin : g_inner
      assign nxt_v   = v_a[i+1];
      assign nxt_h   = h_a[i+1];
      assign nxt_pos = pos_a[i+1];
    end

    tkpp_cell #(
      .SB (SAMPLE_BITS),
      .PW (PW),
      .IW (IW),
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .min_idx   (sc_idx_a[MAX_PEAKS-1]),
      .new_h     (new_h),
      .new_pos   (new_pos),
      .prev_v    (prev_v),
      .nxt_v     (nxt_v),
      .nxt_h     (nxt_h),
      .nxt_pos   (nxt_pos),
      .sc_go_in  (sc_go_in),
      .sc_h_in   (sc_h_in),
      .sc_idx_in (sc_idx_in),
      .v         (v_a[i]),
      .h         (h_a[i]),
      .pos       (pos_a[i]),
      .sc_go_out (sc_go_a[i]),
      .sc_h_out  (sc_h_a[i]),
      .sc_idx_out(sc_idx_a[i])
    );
  end

  if (MAX_PEAKS > 1) begin : g_next0
    assign next0_v = v_a[1];
  end else begin : g_no_next0
    assign next0_v = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_RUN: begin
        if (in_acc) begin
          if (scan_start) begin
            state_nxt = S_SCAN;
          end else if (in_end_of_frame) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = eof_pend_r ? S_DRAIN : S_RUN;
        end
      end
      S_DRAIN: begin
        if (frame_end) begin
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_RUN;
      thr_r        <= '0;
      mp_r         <= tkpp_pkg::MAX_PEAKS_RESET;
      pos_r        <= '0;
      on_peak_r    <= 1'b0;
      best_slope_r <= '1;
      best_pos_r   <= '0;
      best_h_r     <= '0;
      ovf_r        <= 1'b0;
      count_r      <= '0;
      eof_pend_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tkpp_pkg::CFG_THRESHOLD: thr_r <= cfg_data;
          tkpp_pkg::CFG_MAX_PEAKS: mp_r  <= cfg_data[tkpp_pkg::MP_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        eof_pend_r <= in_end_of_frame;
        if (!in_range) begin
          ovf_r <= 1'b1;
        end else begin
          pos_r <= pos_r + PCW'(1);
        end
      end

      if (start_pk || better) begin
        on_peak_r    <= 1'b1;
        best_slope_r <= slope;
        best_pos_r   <= centre;
        best_h_r     <= w1_r;
      end else if (close_pk) begin
        on_peak_r    <= 1'b0;
        best_slope_r <= '1;
      end

      if (cmd.app) begin
        count_r <= count_r + CW'(1);
      end

      // frame done: return frame state to reset
      if (frame_end) begin
        pos_r        <= '0;
        on_peak_r    <= 1'b0;
        best_slope_r <= '1;
        best_pos_r   <= '0;
        best_h_r     <= '0;
        ovf_r        <= 1'b0;
        count_r      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_range) begin
      w0_r <= w1_r;
      w1_r <= in_sample;
    end
    if (close_pk) begin
      pend_h_r   <= best_h_r;
      pend_pos_r <= best_pos_r;
    end
  end

  assign out_valid          = (state_r == S_DRAIN);
  assign out_peak_index     = v_a[0] ? pos_a[0] : '0;
  assign out_peak_count     = tkpp_pkg::COUNT_W'(count_r);
  assign out_none_found     = (count_r == '0);
  assign out_frame_overflow = ovf_r;
  assign out_last_result    = (count_r == '0) || !next0_v;

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS   = 16;
  localparam int FRAME_LIMIT = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int IDX_W       = $clog2(FRAME_LIMIT);

  // indexes outside the register map; writes there must change nothing
  localparam logic [tkpp_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [tkpp_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       eof;
  } spectrum_item_t;

  typedef struct {
    logic [IDX_W-1:0]             index;
    logic [tkpp_pkg::COUNT_W-1:0] count;
    logic                         none_found;
    logic                         overflow;
    logic                         last_result;
  } peak_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic signed [SAMPLE_W-1:0]     in_sample = '0;
  logic                           in_end_of_frame = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [IDX_W-1:0]               out_peak_index;
  logic [tkpp_pkg::COUNT_W-1:0]   out_peak_count;
  logic                           out_none_found;
  logic                           out_frame_overflow;
  logic                           out_last_result;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tkpp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tkpp_pkg::THR_W-1:0]     cfg_data = '0;

  top_k_concave_peak_picker #(
    .MAX_PEAKS  (NUM_SLOTS),
    .MAX_FRAME  (FRAME_LIMIT),
    .SAMPLE_BITS(SAMPLE_W)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_end_of_frame   (in_end_of_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_peak_index    (out_peak_index),
    .out_peak_count    (out_peak_count),
    .out_none_found    (out_none_found),
    .out_frame_overflow(out_frame_overflow),
    .out_last_result   (out_last_result),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  // stimulus and bookkeeping
  spectrum_item_t sample_queue[$];
  spectrum_item_t next_item;
  peak_result_t   expected_peaks[$];
  peak_result_t   want_res;
  int unsigned    n_sent = 0;
  int unsigned    n_taken = 0;
  int             idle_pct = 18;
  bit             hold_req = 1'b0;
  bit             hold_ack = 1'b0;
  int             hold_left = 0;
  int             failures = 0;
  int             frames_done = 0;
  int             overflow_frames = 0;
  int             results_checked = 0;
  int             reg_writes = 0;

  // peak picker state as the block should hold it
  int                           cur_thr = 0;
  logic [tkpp_pkg::MP_W-1:0]    cur_mp = tkpp_pkg::MAX_PEAKS_RESET;
  logic signed [SAMPLE_W-1:0]   win_prev2;
  logic signed [SAMPLE_W-1:0]   win_prev1;
  int unsigned                  frame_pos;
  bit                           peak_open;
  logic [16:0]                  best_slope;
  logic [IDX_W-1:0]             best_pos;
  logic signed [SAMPLE_W-1:0]   best_h;
  logic signed [SAMPLE_W-1:0]   store_h[NUM_SLOTS];
  logic [IDX_W-1:0]             store_p[NUM_SLOTS];
  int unsigned                  store_n;
  bit                           frame_ovf;

  function automatic void clear_frame_state();
    frame_pos  = 0;
    peak_open  = 1'b0;
    best_slope = '1;
    best_pos   = '0;
    best_h     = '0;
    store_n    = 0;
    frame_ovf  = 1'b0;
  endfunction

  function automatic void store_peak(logic signed [SAMPLE_W-1:0] h, logic [IDX_W-1:0] p);
    int unsigned lim;
    int unsigned m;
    lim = (cur_mp == 0) ? 1 : ((cur_mp > NUM_SLOTS) ? NUM_SLOTS : cur_mp);
    if (store_n < lim) begin
      store_h[store_n] = h;
      store_p[store_n] = p;
      store_n++;
      return;
    end
    // evict the earliest of the lowest, keep arrival order
    m = 0;
    for (int unsigned i = 1; i < store_n; i++)
      if (store_h[i] < store_h[m]) m = i;
    if (h < store_h[m]) return;
    for (int unsigned i = m; i + 1 < store_n; i++) begin
      store_h[i] = store_h[i+1];
      store_p[i] = store_p[i+1];
    end
    store_h[store_n-1] = h;
    store_p[store_n-1] = p;
  endfunction

  function automatic void judge_window(logic signed [SAMPLE_W-1:0] a,
                                       logic signed [SAMPLE_W-1:0] b,
                                       logic signed [SAMPLE_W-1:0] c,
                                       logic [IDX_W-1:0] centre);
    int          d;
    int          diff;
    logic [16:0] slope;
    d     = int'(a) + int'(c) - 2 * int'(b);
    diff  = int'(c) - int'(a);
    slope = 17'((diff < 0) ? -diff : diff);
    if (!peak_open) begin
      if (d < cur_thr) begin
        peak_open  = 1'b1;
        best_slope = slope;
        best_pos   = centre;
        best_h     = b;
      end
    end else if (d > cur_thr) begin
      store_peak(best_h, best_pos);
      peak_open  = 1'b0;
      best_slope = '1;
    end else if (slope < best_slope) begin
      best_slope = slope;
      best_pos   = centre;
      best_h     = b;
    end
  endfunction

  function automatic void take_sample(logic signed [SAMPLE_W-1:0] s, logic eof);
    peak_result_t r;
    if (frame_pos >= FRAME_LIMIT) begin
      frame_ovf = 1'b1;
    end else begin
      if (frame_pos >= 2) judge_window(win_prev2, win_prev1, s, IDX_W'(frame_pos - 1));
      win_prev2 = win_prev1;
      win_prev1 = s;
      frame_pos++;
    end
    if (!eof) return;
    frames_done++;
    if (frame_ovf) overflow_frames++;
    if (store_n == 0) begin
      r.index       = '0;
      r.count       = '0;
      r.none_found  = 1'b1;
      r.overflow    = frame_ovf;
      r.last_result = 1'b1;
      expected_peaks.push_back(r);
    end else begin
      for (int unsigned i = 0; i < store_n; i++) begin
        r.index       = store_p[i];
        r.count       = tkpp_pkg::COUNT_W'(store_n);
        r.none_found  = 1'b0;
        r.overflow    = frame_ovf;
        r.last_result = (i + 1 == store_n);
        expected_peaks.push_back(r);
      end
    end
    clear_frame_state();
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // input driver: advance only when the previous transaction was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || n_taken == n_sent) begin
      if (sample_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        next_item = sample_queue.pop_front();
        in_valid        <= 1'b1;
        in_sample       <= next_item.sample;
        in_end_of_frame <= next_item.eof;
        n_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // accept inputs into the predictor and check results
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      take_sample(in_sample, in_end_of_frame);
      n_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_peaks.size() == 0) begin
        $error("result with nothing pending: peak_index %0d", out_peak_index);
        failures++;
      end else begin
        want_res = expected_peaks.pop_front();
        check_field("peak_index", want_res.index, out_peak_index);
        check_field("peak_count", want_res.count, out_peak_count);
        check_field("none_found", want_res.none_found, out_none_found);
        check_field("frame_overflow", want_res.overflow, out_frame_overflow);
        check_field("last_result", want_res.last_result, out_last_result);
        results_checked++;
      end
    end
  end

  task automatic push_sample(int v, bit eof);
    spectrum_item_t it;
    it.sample = v[SAMPLE_W-1:0];
    it.eof    = eof;
    sample_queue.push_back(it);
  endtask

  task automatic push_frame(int len, bit ramps_only);
    int style;
    int y;
    int slope;
    int mag;
    int run;
    int base;
    int h1;
    int h2;
    int v;
    style = ramps_only ? 9 : $urandom_range(0, 9);
    y     = int'($urandom_range(0, 40000)) - 20000;
    slope = 0;
    run   = 0;
    base  = int'($urandom_range(0, 45535)) - 32768;
    h1    = $urandom_range(1, 20000);
    h2    = $urandom_range(0, 1) ? h1 : int'($urandom_range(1, 20000));
    for (int i = 0; i < len; i++) begin
      if (style < 3) begin
        v = int'($urandom_range(0, 65535)) - 32768;
      end else if (style < 5) begin
        // alternating bumps from two heights: many equal peaks
        v = (i % 2 == 0) ? base : base + ($urandom_range(0, 1) ? h1 : h2);
      end else begin
        // ramps with random turning points and a little jitter
        if (run == 0) begin
          run = $urandom_range(1, 6);
          mag = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 30000))
                                            : int'($urandom_range(0, 3000));
          slope = (slope > 0) ? -mag : mag;
        end
        run--;
        y = y + slope + int'($urandom_range(0, 2)) - 1;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        v = y;
      end
      push_sample(v, i == len - 1);
    end
  endtask

  task automatic stream_random_frames(int budget);
    int pushed;
    int r;
    int len;
    pushed = 0;
    while (pushed < budget) begin
      r = $urandom_range(0, 9);
      len = (r == 0) ? int'($urandom_range(1, 2)) :
            (r == 1) ? int'($urandom_range(40, 120)) : int'($urandom_range(3, 30));
      push_frame(len, 1'b0);
      pushed += len;
    end
  endtask

  task automatic write_reg(logic [tkpp_pkg::CFG_IDX_W-1:0] idx,
                           logic [tkpp_pkg::THR_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == tkpp_pkg::CFG_THRESHOLD) cur_thr = int'($signed(data));
    else if (idx == tkpp_pkg::CFG_MAX_PEAKS) cur_mp = data[tkpp_pkg::MP_W-1:0];
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every sample is taken and every result is back, then let
  // a full store update run out before touching the registers
  task automatic settle();
    while (sample_queue.size() != 0 || n_taken != n_sent) @(posedge clk);
    while (expected_peaks.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 4) @(posedge clk);
  endtask

  initial begin
    clear_frame_state();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // short frames, single peaks, an open peak, full-scale samples, flat run
    push_sample(7, 1'b1);
    push_sample(-32768, 1'b0); push_sample(32767, 1'b1);
    push_sample(0, 1'b0); push_sample(100, 1'b0); push_sample(0, 1'b0);
    push_sample(0, 1'b1);
    push_sample(0, 1'b0); push_sample(100, 1'b0); push_sample(0, 1'b1);
    push_sample(-32768, 1'b0); push_sample(32767, 1'b0); push_sample(-32768, 1'b0);
    push_sample(-32768, 1'b1);
    push_sample(5, 1'b0); push_sample(5, 1'b0); push_sample(5, 1'b0); push_sample(5, 1'b1);
    settle();

    // small store, equal heights, long receiver hold-off
    write_reg(tkpp_pkg::CFG_THRESHOLD, 18'd0);
    write_reg(tkpp_pkg::CFG_MAX_PEAKS, 18'd2);
    for (int i = 0; i < 3; i++) begin
      push_sample(0, 1'b0);
      push_sample(5, 1'b0);
    end
    push_sample(0, 1'b0);
    push_sample(0, 1'b1);
    hold_req = ~hold_req;
    stream_random_frames(20);
    settle();

    // lowest threshold: nothing can start a peak
    write_reg(tkpp_pkg::CFG_THRESHOLD, 18'(-131072));
    write_reg(tkpp_pkg::CFG_MAX_PEAKS, 18'd16);
    stream_random_frames(15);
    settle();

    // highest threshold: peaks open but never close
    write_reg(tkpp_pkg::CFG_THRESHOLD, 18'(131071));
    write_reg(tkpp_pkg::CFG_MAX_PEAKS, 18'd5);
    stream_random_frames(15);
    settle();

    // unmapped indexes, max_peaks of zero, no idling on either side
    write_reg(CFG_SPARE_A, 18'($urandom_range(0, 262143)));
    write_reg(CFG_SPARE_B, 18'($urandom_range(0, 262143)));
    write_reg(tkpp_pkg::CFG_THRESHOLD, 18'(-40));
    write_reg(tkpp_pkg::CFG_MAX_PEAKS, {13'($urandom_range(0, 8191)), 5'd0});
    idle_pct = 0;
    stream_random_frames(30);
    settle();
    idle_pct = 18;

    write_reg(tkpp_pkg::CFG_THRESHOLD, 18'(25));
    write_reg(tkpp_pkg::CFG_MAX_PEAKS, {13'($urandom_range(0, 8191)), 5'd1});
    stream_random_frames(25);
    settle();

    write_reg(tkpp_pkg::CFG_THRESHOLD, 18'(0));
    write_reg(tkpp_pkg::CFG_MAX_PEAKS, 18'd31);
    stream_random_frames(15);
    settle();

    for (int p = 0; p < 4; p++) begin
      if ($urandom_range(0, 3) == 0) begin
        write_reg(tkpp_pkg::CFG_THRESHOLD, 18'($urandom_range(0, 262143)));
      end else begin
        write_reg(tkpp_pkg::CFG_THRESHOLD, 18'(int'($urandom_range(0, 6000)) - 3000));
      end
      write_reg(tkpp_pkg::CFG_MAX_PEAKS, 18'($urandom_range(0, 262143)));
      stream_random_frames(15);
      settle();
    end

    $display("Covered %0d frames (%0d past the length limit), %0d samples, %0d results.",
             frames_done, overflow_frames, n_taken, results_checked);
    $display("Used %0d register writes, thresholds at both extremes, max_peaks 0 to 31.",
             reg_writes);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
